// ===== sv/gcmsf_pkg.sv =====
`default_nettype none
package gcmsf_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] REG_SPACING = 2'd0;
    localparam logic [1:0] REG_SIZE_X  = 2'd1;
    localparam logic [1:0] REG_SIZE_Y  = 2'd2;
    localparam logic [1:0] REG_SIZE_Z  = 2'd3;

    // register reset values
    localparam logic [8:0]  SPACING_RST = 9'd8;
    localparam logic [12:0] SIZE_X_RST  = 13'd256;
    localparam logic [12:0] SIZE_Y_RST  = 13'd256;
    localparam logic [12:0] SIZE_Z_RST  = 13'd64;

    // starting value of a cell minimum
    localparam logic [7:0] VAL_MAX = 8'd255;

    // width of one stored cell record
    localparam int REC_W = 44;

    // one stored cell record: position of the minimum and the minimum
    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] z;
        logic [7:0]  val;
    } t_rec;

    // what the position walker hands to the cell update stage
    typedef struct packed {
        logic        used;
        logic        first;
        logic        seed_end;
        logic        last_cell;
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] z;
        logic [7:0]  value;
    } t_step;

endpackage
`default_nettype wire

// ===== sv/grid_cell_min_seed_finder_3d.sv =====
`default_nettype none
// channel   | direction | handshake                      | payload
// ----------+-----------+--------------------------------+---------------------------------
// voxel     | in        | i_voxel_valid / o_voxel_ready  | i_voxel_value, i_volume_start
// seed      | out       | o_seed_valid  / i_seed_ready   | o_seed_x/y/z, o_seed_value,
//           |           |                                | o_last_seed
// config    | in        | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// one voxel a cycle; each voxel in a used cell does one read-modify-write of its cell record
// a seed passes the update stage and then the output register after the last voxel of its cell is taken
// the record memory's single read and write port set the rate; same-slot overlap is forwarded
// synchronous active-low reset clears position and pipeline and loads the register reset values; no clearing pass
// a seed waiting on i_seed_ready holds the update stage and with it o_voxel_ready
module grid_cell_min_seed_finder_3d #(
    parameter int MAX_DIM   = 4096,
    parameter int MAX_CELLS = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_voxel_valid,
    output logic             o_voxel_ready,
    input  wire logic [7:0]  i_voxel_value,
    input  wire logic        i_volume_start,
    output logic             o_seed_valid,
    input  wire logic        i_seed_ready,
    output logic [11:0]      o_seed_x,
    output logic [11:0]      o_seed_y,
    output logic [11:0]      o_seed_z,
    output logic [7:0]       o_seed_value,
    output logic             o_last_seed,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import gcmsf_pkg::*;

    localparam int LW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    logic [8:0]  r_grid_spacing;
    logic [12:0] r_size_x, r_size_y, r_size_z;

    logic          accept;
    logic          cfg_wr;
    t_step         step;
    logic [LW-1:0] slot;
    logic          we;
    logic [LW-1:0] wr_slot;
    t_rec          wr_rec;
    logic [REC_W-1:0] rd_data;
    t_rec          rd_rec;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = i_voxel_valid && o_voxel_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_spacing <= SPACING_RST;
            r_size_x       <= SIZE_X_RST;
            r_size_y       <= SIZE_Y_RST;
            r_size_z       <= SIZE_Z_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SPACING: r_grid_spacing <= pwdata[8:0];
                REG_SIZE_X:  r_size_x       <= pwdata[12:0];
                REG_SIZE_Y:  r_size_y       <= pwdata[12:0];
                REG_SIZE_Z:  r_size_z       <= pwdata[12:0];
                default: begin
                end
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (paddr[3:2])
            REG_SPACING: prdata = 32'(r_grid_spacing);
            REG_SIZE_X:  prdata = 32'(r_size_x);
            REG_SIZE_Y:  prdata = 32'(r_size_y);
            REG_SIZE_Z:  prdata = 32'(r_size_z);
            default:     prdata = '0;
        endcase
    end

    // position walker and slot lookup
    gcmsf_walk #(
        .MAX_DIM   (MAX_DIM),
        .MAX_CELLS (MAX_CELLS)
    ) u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_voxel_value  (i_voxel_value),
        .i_volume_start (i_volume_start),
        .i_grid_spacing (r_grid_spacing),
        .i_size_x       (r_size_x),
        .i_size_y       (r_size_y),
        .i_size_z       (r_size_z),
        .o_step         (step),
        .o_slot         (slot)
    );

    // cell record memory
    gcmsf_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_slot),
        .i_wdata (REC_W'(wr_rec)),
        .i_re    (accept),
        .i_raddr (slot),
        .o_rdata (rd_data)
    );

    assign rd_rec = t_rec'(rd_data);

    // record update and seed output
    gcmsf_cell #(
        .MAX_CELLS (MAX_CELLS)
    ) u_cell (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_step       (step),
        .i_slot       (slot),
        .i_rd_rec     (rd_rec),
        .i_seed_ready (i_seed_ready),
        .o_ready      (o_voxel_ready),
        .o_we         (we),
        .o_wr_slot    (wr_slot),
        .o_wr_rec     (wr_rec),
        .o_seed_valid (o_seed_valid),
        .o_seed_x     (o_seed_x),
        .o_seed_y     (o_seed_y),
        .o_seed_z     (o_seed_z),
        .o_seed_value (o_seed_value),
        .o_last_seed  (o_last_seed)
    );

endmodule
`default_nettype wire

// ===== sv/gcmsf_ram.sv =====
`default_nettype none
module gcmsf_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 4096
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // single write port, registered read port (read-first)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/gcmsf_walk.sv =====
`default_nettype none
module gcmsf_walk #(
    parameter int MAX_DIM   = 4096,
    parameter int MAX_CELLS = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_voxel_value,
    input  wire logic                 i_volume_start,
    input  wire logic [8:0]           i_grid_spacing,
    input  wire logic [12:0]          i_size_x,
    input  wire logic [12:0]          i_size_y,
    input  wire logic [12:0]          i_size_z,
    output gcmsf_pkg::t_step          o_step,
    output logic [((MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1)-1:0] o_slot
);

    import gcmsf_pkg::*;

    localparam int DW = $clog2(MAX_DIM);
    localparam int AW = ((DW > 13) ? DW : 13) + 2;
    localparam int SW = $clog2(MAX_CELLS) + 1;
    localparam int RW = ((SW > DW) ? SW : DW) + 1;
    localparam int LW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    // size zero acts as one, sizes above the maximum are clipped
    function automatic logic [AW-1:0] eff_size(input logic [12:0] s);
        logic [AW-1:0] w;
        w = AW'(s);
        if (s == 13'd0) begin
            w = AW'(1);
        end else if (w > AW'(MAX_DIM)) begin
            w = AW'(MAX_DIM);
        end
        return w;
    endfunction

    logic [DW-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [DW-1:0] r_start_x, r_start_y, r_start_z;
    logic [7:0]    r_off_x, r_off_y, r_off_z;
    logic [DW-1:0] r_cell_x;
    logic [SW-1:0] r_row_base;

    logic [DW-1:0] n_pos_x, n_pos_y, n_pos_z;
    logic [DW-1:0] n_start_x, n_start_y, n_start_z;
    logic [7:0]    n_off_x, n_off_y, n_off_z;
    logic [DW-1:0] n_cell_x;
    logic [SW-1:0] n_row_base;

    logic [DW-1:0] c_pos_x, c_pos_y, c_pos_z;
    logic [DW-1:0] c_start_x, c_start_y, c_start_z;
    logic [7:0]    c_off_x, c_off_y, c_off_z;
    logic [DW-1:0] c_cell_x;
    logic [SW-1:0] c_row_base;

    logic [AW-1:0] sx, sy, sz, gz;
    logic [8:0]    gm1;
    logic [RW-1:0] slot_sum;
    logic [RW-1:0] row_sum;
    logic          wrap_x, wrap_y, wrap_z;
    logic          end_x, end_y, end_z;

    assign sx  = eff_size(i_size_x);
    assign sy  = eff_size(i_size_y);
    assign sz  = eff_size(i_size_z);
    assign gz  = AW'(i_grid_spacing);
    assign gm1 = i_grid_spacing - 9'd1;

    // position of this voxel after a volume start or an out-of-range position
    always_comb begin
        c_pos_x    = r_pos_x;
        c_pos_y    = r_pos_y;
        c_pos_z    = r_pos_z;
        c_start_x  = r_start_x;
        c_start_y  = r_start_y;
        c_start_z  = r_start_z;
        c_off_x    = r_off_x;
        c_off_y    = r_off_y;
        c_off_z    = r_off_z;
        c_cell_x   = r_cell_x;
        c_row_base = r_row_base;
        if (i_volume_start) begin
            c_pos_x    = '0;
            c_pos_y    = '0;
            c_pos_z    = '0;
            c_start_x  = '0;
            c_start_y  = '0;
            c_start_z  = '0;
            c_off_x    = '0;
            c_off_y    = '0;
            c_off_z    = '0;
            c_cell_x   = '0;
            c_row_base = '0;
        end
        if (AW'(c_pos_x) >= sx) begin
            c_pos_x   = '0;
            c_start_x = '0;
            c_off_x   = '0;
            c_cell_x  = '0;
        end
        if (AW'(c_pos_y) >= sy) begin
            c_pos_y    = '0;
            c_start_y  = '0;
            c_off_y    = '0;
            c_row_base = '0;
        end
        if (AW'(c_pos_z) >= sz) begin
            c_pos_z   = '0;
            c_start_z = '0;
            c_off_z   = '0;
        end
    end

    // cell membership, slot and cell corners
    assign slot_sum = RW'(c_row_base) + RW'(c_cell_x);
    assign end_x    = ({1'b0, c_off_x} == gm1);
    assign end_y    = ({1'b0, c_off_y} == gm1);
    assign end_z    = ({1'b0, c_off_z} == gm1);

    always_comb begin
        o_step.used = (i_grid_spacing != 9'd0)
                   && (AW'(c_start_x) + gz < sx)
                   && (AW'(c_start_y) + gz < sy)
                   && (AW'(c_start_z) + gz < sz)
                   && (slot_sum < RW'(MAX_CELLS));
        o_step.first     = (c_off_x == 8'd0) && (c_off_y == 8'd0) && (c_off_z == 8'd0);
        o_step.seed_end  = end_x && end_y && end_z;
        o_step.last_cell = (AW'(c_start_x) + gz + gz >= sx)
                        && (AW'(c_start_y) + gz + gz >= sy)
                        && (AW'(c_start_z) + gz + gz >= sz);
        o_step.x         = 12'(c_pos_x);
        o_step.y         = 12'(c_pos_y);
        o_step.z         = 12'(c_pos_z);
        o_step.value     = i_voxel_value;
    end

    assign o_slot = LW'(slot_sum);

    // raster advance: x fastest, then y, then z
    assign wrap_x  = (AW'(c_pos_x) + AW'(1) >= sx);
    assign wrap_y  = (AW'(c_pos_y) + AW'(1) >= sy);
    assign wrap_z  = (AW'(c_pos_z) + AW'(1) >= sz);
    assign row_sum = RW'(c_row_base) + RW'(c_cell_x);

    always_comb begin
        n_pos_x    = c_pos_x;
        n_pos_y    = c_pos_y;
        n_pos_z    = c_pos_z;
        n_start_x  = c_start_x;
        n_start_y  = c_start_y;
        n_start_z  = c_start_z;
        n_off_x    = c_off_x;
        n_off_y    = c_off_y;
        n_off_z    = c_off_z;
        n_cell_x   = c_cell_x;
        n_row_base = c_row_base;
        if (!wrap_x) begin
            n_pos_x = c_pos_x + DW'(1);
            if (end_x) begin
                n_off_x   = '0;
                n_start_x = c_start_x + DW'(i_grid_spacing);
                n_cell_x  = c_cell_x + DW'(1);
            end else begin
                n_off_x = c_off_x + 8'd1;
            end
        end else begin
            n_pos_x   = '0;
            n_off_x   = '0;
            n_start_x = '0;
            n_cell_x  = '0;
            if (!wrap_y) begin
                n_pos_y = c_pos_y + DW'(1);
                if (end_y) begin
                    // the row just finished counted the used cells of a row
                    n_off_y   = '0;
                    n_start_y = c_start_y + DW'(i_grid_spacing);
                    if (row_sum >= RW'(MAX_CELLS)) begin
                        n_row_base = SW'(MAX_CELLS);
                    end else begin
                        n_row_base = SW'(row_sum);
                    end
                end else begin
                    n_off_y = c_off_y + 8'd1;
                end
            end else begin
                n_pos_y    = '0;
                n_off_y    = '0;
                n_start_y  = '0;
                n_row_base = '0;
                if (!wrap_z) begin
                    n_pos_z = c_pos_z + DW'(1);
                    if (end_z) begin
                        n_off_z   = '0;
                        n_start_z = c_start_z + DW'(i_grid_spacing);
                    end else begin
                        n_off_z = c_off_z + 8'd1;
                    end
                end else begin
                    n_pos_z   = '0;
                    n_off_z   = '0;
                    n_start_z = '0;
                end
            end
        end
    end

    // position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_pos_z    <= '0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_start_z  <= '0;
            r_off_x    <= '0;
            r_off_y    <= '0;
            r_off_z    <= '0;
            r_cell_x   <= '0;
            r_row_base <= '0;
        end else if (i_accept) begin
            r_pos_x    <= n_pos_x;
            r_pos_y    <= n_pos_y;
            r_pos_z    <= n_pos_z;
            r_start_x  <= n_start_x;
            r_start_y  <= n_start_y;
            r_start_z  <= n_start_z;
            r_off_x    <= n_off_x;
            r_off_y    <= n_off_y;
            r_off_z    <= n_off_z;
            r_cell_x   <= n_cell_x;
            r_row_base <= n_row_base;
        end
    end

endmodule
`default_nettype wire

// ===== sv/gcmsf_cell.sv =====
`default_nettype none
module gcmsf_cell #(
    parameter int MAX_CELLS = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  gcmsf_pkg::t_step          i_step,
    input  wire logic [((MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1)-1:0] i_slot,
    input  gcmsf_pkg::t_rec           i_rd_rec,
    input  wire logic                 i_seed_ready,
    output logic                      o_ready,
    output logic                      o_we,
    output logic [((MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1)-1:0] o_wr_slot,
    output gcmsf_pkg::t_rec           o_wr_rec,
    output logic                      o_seed_valid,
    output logic [11:0]               o_seed_x,
    output logic [11:0]               o_seed_y,
    output logic [11:0]               o_seed_z,
    output logic [7:0]                o_seed_value,
    output logic                      o_last_seed
);

    import gcmsf_pkg::*;

    localparam int LW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    logic          r_s1_valid;
    t_step         r_s1;
    logic [LW-1:0] r_s1_slot;
    logic          r_last_valid;
    logic [LW-1:0] r_last_slot;
    t_rec          r_last_rec;
    logic          r_seed_valid;
    t_rec          r_seed;
    logic          r_seed_last;

    t_rec base_rec;
    t_rec new_rec;
    logic fwd;
    logic produce;
    logic s1_adv;

    // stall when a seed is due but the output register stays full
    assign produce   = r_s1.used && r_s1.seed_end;
    assign s1_adv    = r_s1_valid && (!produce || !r_seed_valid || i_seed_ready);
    assign o_ready   = !r_s1_valid || s1_adv;
    assign o_we      = s1_adv && r_s1.used;
    assign o_wr_slot = r_s1_slot;
    assign o_wr_rec  = new_rec;

    // newest write to the same slot overrides the memory read
    assign fwd = r_last_valid && (r_last_slot == r_s1_slot);

    // read-modify: restart at the cell origin, keep strictly smaller values
    always_comb begin
        if (r_s1.first) begin
            base_rec = '{x: r_s1.x, y: r_s1.y, z: r_s1.z, val: VAL_MAX};
        end else if (fwd) begin
            base_rec = r_last_rec;
        end else begin
            base_rec = i_rd_rec;
        end
        new_rec = base_rec;
        if (r_s1.value < base_rec.val) begin
            new_rec = '{x: r_s1.x, y: r_s1.y, z: r_s1.z, val: r_s1.value};
        end
    end

    // update stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (i_accept) begin
            r_s1      <= i_step;
            r_s1_slot <= i_slot;
        end
    end

    // copy of the latest write-back for forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_valid <= 1'b0;
        end else if (o_we) begin
            r_last_valid <= 1'b1;
        end
        if (o_we) begin
            r_last_slot <= r_s1_slot;
            r_last_rec  <= new_rec;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_valid <= 1'b0;
        end else if (s1_adv && produce) begin
            r_seed_valid <= 1'b1;
        end else if (i_seed_ready) begin
            r_seed_valid <= 1'b0;
        end
        if (s1_adv && produce) begin
            r_seed      <= new_rec;
            r_seed_last <= r_s1.last_cell;
        end
    end

    assign o_seed_valid = r_seed_valid;
    assign o_seed_x     = r_seed.x;
    assign o_seed_y     = r_seed.y;
    assign o_seed_z     = r_seed.z;
    assign o_seed_value = r_seed.val;
    assign o_last_seed  = r_seed_last;

    // write-back only for a held request inside a used cell
    a_we_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_s1_valid && r_s1.used))
        else $error("cell write without a used request");

    // a finished cell always shows up on the output next cycle
    a_seed_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && produce) |=> o_seed_valid)
        else $error("finished cell did not reach the output");

    // no new request while a seed is blocked behind a full output
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && produce && o_seed_valid && !i_seed_ready) |-> !i_accept)
        else $error("request taken while update stage blocked");

    // forwarded record always comes from an earlier write
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && fwd) |-> r_last_valid)
        else $error("forwarding without a prior write");

endmodule
`default_nettype wire

// ===== dv/grid_cell_min_seed_finder_3d_tb.sv =====
`timescale 1ns / 1ps

module grid_cell_min_seed_finder_3d_tb;
    import gcmsf_pkg::*;

    localparam int unsigned DIM_LIMIT       = 4096;
    localparam int unsigned CELL_LIMIT      = 4096;
    localparam int unsigned RANDOM_TARGET   = 1850;
    localparam int unsigned CALM_TAIL       = 250;
    localparam int unsigned LONG_HOLD       = 400;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam int unsigned MISMATCH_PRINTS = 40;

    // one seed as it leaves the block
    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] z;
        logic [7:0]  val;
        logic        last_cell;
    } seed_t;

    // tracks the volume walk and every cell minimum, queues the seeds due
    class seed_tracker;
        logic [8:0]  spacing;
        logic [12:0] size_x, size_y, size_z;
        int unsigned px, py, pz;
        t_rec        cells [CELL_LIMIT];
        seed_t       pending_seeds [$];
        int unsigned errors;

        function new();
            spacing = SPACING_RST;
            size_x  = SIZE_X_RST;
            size_y  = SIZE_Y_RST;
            size_z  = SIZE_Z_RST;
            px      = 0;
            py      = 0;
            pz      = 0;
            errors  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_SPACING: spacing = data[8:0];
                REG_SIZE_X:  size_x  = data[12:0];
                REG_SIZE_Y:  size_y  = data[12:0];
                REG_SIZE_Z:  size_z  = data[12:0];
                default: ;
            endcase
        endfunction

        // zero behaves as one, anything past the dimension limit is clipped
        function int unsigned clip_size(logic [12:0] s);
            if (s == 0) return 1;
            if (s > DIM_LIMIT) return DIM_LIMIT;
            return s;
        endfunction

        // only cells that end strictly inside the volume count
        function int unsigned cells_along(int unsigned s, int unsigned g);
            if (g == 0 || s <= g) return 0;
            return (s - 1) / g;
        endfunction

        // returns 1 when the voxel lands in a tracked cell
        function bit take_voxel(logic [7:0] v, logic restart);
            int unsigned sx, sy, sz, g, nx, ny, nz, cx, cy, cz, slot;
            bit          used;
            seed_t       s;
            sx   = clip_size(size_x);
            sy   = clip_size(size_y);
            sz   = clip_size(size_z);
            g    = spacing;
            nx   = cells_along(sx, g);
            ny   = cells_along(sy, g);
            nz   = cells_along(sz, g);
            used = 1'b0;
            if (restart) begin
                px = 0;
                py = 0;
                pz = 0;
            end
            if (px >= sx) px = 0;
            if (py >= sy) py = 0;
            if (pz >= sz) pz = 0;

            if (nx != 0 && ny != 0 && nz != 0 &&
                px < nx * g && py < ny * g && pz < nz * g) begin
                cx   = px / g;
                cy   = py / g;
                cz   = pz / g;
                slot = cy * nx + cx;
                if (slot < CELL_LIMIT) begin
                    used = 1'b1;
                    // cell origin opens the record at the ceiling value
                    if (px % g == 0 && py % g == 0 && pz % g == 0)
                        cells[slot] = '{12'(px), 12'(py), 12'(pz), VAL_MAX};
                    // strictly smaller only, so ties keep the earlier voxel
                    if (v < cells[slot].val)
                        cells[slot] = '{12'(px), 12'(py), 12'(pz), v};
                    if (px % g == g - 1 && py % g == g - 1 && pz % g == g - 1) begin
                        s.x         = cells[slot].x;
                        s.y         = cells[slot].y;
                        s.z         = cells[slot].z;
                        s.val       = cells[slot].val;
                        s.last_cell = (cx == nx - 1 && cy == ny - 1 && cz == nz - 1);
                        pending_seeds.push_back(s);
                    end
                end
            end

            // raster walk, x fastest, wrapping at the end of the volume
            px++;
            if (px >= sx) begin
                px = 0;
                py++;
                if (py >= sy) begin
                    py = 0;
                    pz++;
                    if (pz >= sz) pz = 0;
                end
            end
            return used;
        endfunction

        function void check_seed(seed_t got);
            seed_t want;
            if (pending_seeds.size() == 0) begin
                errors++;
                if (errors <= MISMATCH_PRINTS)
                    $display("%0t: seed with none expected: x=%0d y=%0d z=%0d value=%0d last=%0b",
                             $time, got.x, got.y, got.z, got.val, got.last_cell);
                return;
            end
            want = pending_seeds.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.val !== want.val || got.last_cell !== want.last_cell) begin
                errors++;
                // keep the log short when the block is badly off
                if (errors <= MISMATCH_PRINTS)
                    $display({"%0t: seed wrong: expected x=%0d y=%0d z=%0d value=%0d last=%0b,",
                              " actual x=%0d y=%0d z=%0d value=%0d last=%0b"},
                             $time, want.x, want.y, want.z, want.val, want.last_cell,
                             got.x, got.y, got.z, got.val, got.last_cell);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_voxel_valid;
    logic        o_voxel_ready;
    logic [7:0]  i_voxel_value;
    logic        i_volume_start;
    logic        o_seed_valid;
    logic        i_seed_ready;
    logic [11:0] o_seed_x;
    logic [11:0] o_seed_y;
    logic [11:0] o_seed_z;
    logic [7:0]  o_seed_value;
    logic        o_last_seed;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    seed_tracker book;
    bit          calm;
    bit          long_hold_req;
    bit          tx_gappy;
    int unsigned used_voxels;

    // one cell with a tie on the minimum and a stray low voxel outside it
    logic [7:0] cell_probe [14] = '{8'd200, 8'd180, 8'd9, 8'd150, 8'd0, 8'd77, 8'd66,
                                     8'd55, 8'd44, 8'd90, 8'd0, 8'd3, 8'd0, 8'd255};

    grid_cell_min_seed_finder_3d u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_voxel_valid  (i_voxel_valid),
        .o_voxel_ready  (o_voxel_ready),
        .i_voxel_value  (i_voxel_value),
        .i_volume_start (i_volume_start),
        .o_seed_valid   (o_seed_valid),
        .i_seed_ready   (i_seed_ready),
        .o_seed_x       (o_seed_x),
        .o_seed_y       (o_seed_y),
        .o_seed_z       (o_seed_z),
        .o_seed_value   (o_seed_value),
        .o_last_seed    (o_last_seed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // value mix: plain random, ceiling value and low values that tie
    function automatic logic [7:0] pick_value();
        case ($urandom_range(0, 3))
            0: return VAL_MAX;
            1: return 8'($urandom_range(0, 15));
            default: return 8'($urandom);
        endcase
    endfunction

    // one voxel request, sometimes with a random gap in front of it
    task automatic send_voxel(logic [7:0] v, logic st);
        if (!calm && tx_gappy && $urandom_range(0, 3) == 0) begin
            i_voxel_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        if ($urandom_range(0, 63) == 0) tx_gappy = !tx_gappy;
        i_voxel_valid  <= 1'b1;
        i_voxel_value  <= v;
        i_volume_start <= st;
        @(posedge i_clk);
        while (!o_voxel_ready) @(posedge i_clk);
        if (book.take_voxel(v, st)) used_voxels++;
    endtask

    task automatic send_volume(int unsigned n, logic first_start, bit noisy);
        logic st;
        for (int i = 0; i < n; i++) begin
            st = (i == 0) ? first_start : logic'(noisy && $urandom_range(0, 47) == 0);
            send_voxel(pick_value(), st);
        end
    endtask

    // apb write, setup then access; the caller drops psel after the last one
    task automatic write_reg(logic [1:0] idx, int unsigned data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(data);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        book.set_reg(idx, 32'(data));
    endtask

    // registers change only once the block has gone quiet
    task automatic load_config(int unsigned g, int unsigned sx, int unsigned sy,
                               int unsigned sz);
        i_voxel_valid <= 1'b0;
        while (book.pending_seeds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_SPACING, g);
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // small volumes, mostly whole, some cut short or without cells
    task automatic random_phase();
        int unsigned g, sx, sy, sz, nvol, len;
        g  = $urandom_range(1, 3);
        sx = $urandom_range(g + 1, 2 * g + 2);
        sy = $urandom_range(g + 1, 2 * g + 1);
        sz = $urandom_range(g + 1, 2 * g);
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0: sx = $urandom_range(1, g);
                1: sy = $urandom_range(1, g);
                default: sz = $urandom_range(1, g);
            endcase
        end
        load_config(g, sx, sy, sz);
        nvol = $urandom_range(1, 3);
        for (int v = 0; v < nvol; v++) begin
            len = sx * sy * sz;
            if (v == nvol - 1 && $urandom_range(0, 3) == 0) len = $urandom_range(1, len);
            send_volume(len, (v == 0) ? 1'b1 : logic'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    // seed sink: random stall bursts, plus one long hold on request
    initial begin : seed_sink
        int unsigned stall_left;
        bit          rx_gappy;
        stall_left   = 0;
        rx_gappy     = 1'b1;
        i_seed_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 99) == 0) rx_gappy = !rx_gappy;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_seed_ready <= 1'b0;
            end else if (!calm && rx_gappy && $urandom_range(0, 7) == 0) begin
                stall_left   = $urandom_range(0, 9);
                i_seed_ready <= 1'b0;
            end else begin
                i_seed_ready <= 1'b1;
            end
        end
    end

    // seed checker
    initial begin : seed_monitor
        seed_t got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_seed_valid === 1'b1 && i_seed_ready) begin
                got = '{o_seed_x, o_seed_y, o_seed_z, o_seed_value, o_last_seed};
                book.check_seed(got);
            end
        end
    end

    // watchdog on cycles with no request moving on any port
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_voxel_valid && o_voxel_ready) || (o_seed_valid && i_seed_ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("grid_cell_min_seed_finder_3d: mismatch");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        book           = new();
        calm           = 1'b0;
        long_hold_req  = 1'b0;
        tx_gappy       = 1'b1;
        used_voxels    = 0;
        i_rst_n        = 1'b0;
        i_voxel_valid  = 1'b0;
        i_voxel_value  = 8'd0;
        i_volume_start = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = 4'd0;
        pwdata         = 32'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one cell in a 3x3x3 volume: all at the ceiling, then a tied minimum
        load_config(2, 3, 3, 3);
        for (int i = 0; i < 14; i++) send_voxel(VAL_MAX, i == 0);
        for (int i = 0; i < 14; i++) send_voxel(cell_probe[i], i == 0);

        // unit cells with wrap into the next volume
        load_config(1, 2, 2, 2);
        send_volume(16, 1'b1, 1'b0);
        // zero spacing, zero size, size equal to spacing: nothing comes out
        load_config(0, 5, 5, 5);
        send_volume(20, 1'b1, 1'b0);
        load_config(2, 0, 5, 5);
        send_volume(20, 1'b1, 1'b0);
        load_config(3, 3, 9, 9);
        send_volume(20, 1'b1, 1'b0);
        // largest legal settings, then every register bit set
        load_config(256, 4096, 4096, 4096);
        send_volume(24, 1'b1, 1'b0);
        load_config(511, 8191, 8191, 8191);
        send_volume(24, 1'b1, 1'b0);

        // clipped width and unit cells run the slot index past the record store;
        // the sink holds off meanwhile so the block backs up
        load_config(1, 8191, 3, 2);
        long_hold_req = 1'b1;
        send_volume(DIM_LIMIT + 64, 1'b1, 1'b0);

        used_voxels = 0;
        while (used_voxels < RANDOM_TARGET) begin
            if (used_voxels >= RANDOM_TARGET - CALM_TAIL) calm = 1'b1;
            random_phase();
        end

        // drain and let the pipeline settle
        i_voxel_valid <= 1'b0;
        while (book.pending_seeds.size() != 0) @(posedge i_clk);
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (book.errors == 0 && book.pending_seeds.size() == 0)
            $display("grid_cell_min_seed_finder_3d: match");
        else
            $display("grid_cell_min_seed_finder_3d: mismatch");
        $finish;
    end

endmodule
